@@ rtl/indexed_deque_core_defines.svh @@
// ----------------------------------------------------------------------------
// Indexed deque assertion macros
// Concurrent assertion wrappers used by the indexed deque core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_CORE_DEFINES_SVH
`define INDEXED_DEQUE_CORE_DEFINES_SVH

// same-cycle implication
`define IDQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/idq_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed deque package
// Field widths, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package idq_pkg;

   localparam int KIND_W = 3;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 11;
   localparam int ST_W   = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LENGTH     = 3'd6;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_INDEX = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic            load_req;
      logic            mem_rd;
      logic            mem_wr;
      logic            shift;
      logic            cur_load;
      logic            cur_dec;
      logic            front_dec;
      logic            front_inc;
      logic            count_inc;
      logic            count_dec;
      logic            rsp_load;
      logic            rsp_rdata;
      logic [ST_W-1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              empty;
      logic              full;
      logic              pos_bad;
      logic              cur_more;
      logic              rsp_free;
   } stat_type;

endpackage

@@ rtl/idq_if.sv @@
// ----------------------------------------------------------------------------
// Indexed deque channels
// Request and response valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface idq_req_if import idq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] item_value;

   modport source (output valid, kind, position, item_value, input ready);
   modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface idq_rsp_if import idq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] read_value;
   logic [CNT_W-1:0]        count_now;
   logic [ST_W-1:0]         status;

   modport source (output valid, read_value, count_now, status, input ready);
   modport sink   (input valid, read_value, count_now, status, output ready);
endinterface

@@ rtl/indexed_deque_core.sv @@
// ----------------------------------------------------------------------------
// Indexed deque core
// Bounded deque of signed words in a ring store with indexed insert and read.
//
//   channel    dir   handshake      word
//   req_chan   in    valid/ready    kind, position, item_value
//   rsp_chan   out   valid/ready    read_value, count_now, status
//
// One operation at a time. Pops and reads pass through an extra state for
// the registered store read. Insert moves each item above the position up
// one slot, each move a read and a write through the single store port pair.
// A waiting response stalls completion only; the next word is taken once the
// current one completes. Reset clears length and front slot; the store is
// not cleared.
// ----------------------------------------------------------------------------
`include "indexed_deque_core_defines.svh"

module indexed_deque_core import idq_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   idq_req_if.sink   req_chan,
   idq_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_take;

   assign req_take = req_chan.valid && req_chan.ready;

   idq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   idq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_chan.kind),
      .req_position   (req_chan.position),
      .req_item_value (req_chan.item_value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_count_now  (rsp_chan.count_now),
      .rsp_status     (rsp_chan.status)
   );

   `IDQ_ASSERT_IMPL(a_rsp_slot_free, clock, reset, cmd.rsp_load, stat.rsp_free, "response lost")
   `IDQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_chan.ready, "second word taken")
   `IDQ_ASSERT_IMPL(a_no_grow_full, clock, reset, cmd.count_inc, !stat.full, "grow on full store")
   `IDQ_ASSERT_IMPL(a_no_shrink_empty, clock, reset, cmd.count_dec, !stat.empty, "shrink on empty")

endmodule

@@ rtl/idq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Indexed deque controller
// Sequences one operation at a time and drives datapath commands.
// ----------------------------------------------------------------------------
module idq_ctrl import idq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDATA  = 3'd2;
   localparam logic [2:0] S_SH_CHK = 3'd3;
   localparam logic [2:0] S_SH_WR  = 3'd4;
   localparam logic [2:0] S_INS_WR = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = ST_OK;
      state_in       = state_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.kind)
               KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                  if (stat.rsp_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                     if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.mem_wr    = 1'b1;
                        cmd.count_inc = 1'b1;
                        cmd.front_dec = (stat.kind == KIND_PUSH_FRONT);
                     end
                  end
               end
               KIND_INSERT: begin
                  if (stat.pos_bad || stat.full) begin
                     if (stat.rsp_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = stat.pos_bad ? ST_INDEX : ST_FULL;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.cur_load = 1'b1;
                     state_in     = S_SH_CHK;
                  end
               end
               KIND_POP_FRONT, KIND_POP_BACK: begin
                  if (stat.empty) begin
                     if (stat.rsp_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.mem_rd    = 1'b1;
                     cmd.count_dec = 1'b1;
                     cmd.front_inc = (stat.kind == KIND_POP_FRONT);
                     state_in      = S_RDATA;
                  end
               end
               KIND_READ: begin
                  if (stat.empty || stat.pos_bad) begin
                     if (stat.rsp_free) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = stat.empty ? ST_EMPTY : ST_INDEX;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_RDATA;
                  end
               end
               default: begin
                  if (stat.rsp_free) begin
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_RDATA: begin
            if (stat.rsp_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_rdata = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SH_CHK: begin
            if (stat.cur_more) begin
               cmd.mem_rd = 1'b1;
               cmd.shift  = 1'b1;
               state_in   = S_SH_WR;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_SH_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.shift   = 1'b1;
            cmd.cur_dec = 1'b1;
            state_in    = S_SH_CHK;
         end
         S_INS_WR: begin
            if (stat.rsp_free) begin
               cmd.mem_wr    = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.rsp_load  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/idq_dpath.sv @@
// ----------------------------------------------------------------------------
// Indexed deque datapath
// Ring store, front and length registers, cursor and response register.
// ----------------------------------------------------------------------------
module idq_dpath import idq_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [CNT_W-1:0]        rsp_count_now,
   output logic [ST_W-1:0]         rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;
   localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] idx);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, idx};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[AW-1:0];
   endfunction

   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [POS_W-1:0]        pos_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [AW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           cur_ff, cur_in;
   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic [ST_W-1:0]         rsp_status_ff;

   logic [AW-1:0]           pos_idx, pos1_idx, count_idx, last_idx, cur_idx, cur1_idx;
   logic [AW-1:0]           front_m1, front_p1;
   logic [AW-1:0]           rd_idx, rd_addr, wr_addr;
   logic signed [VAL_W-1:0] wr_data;

   assign pos_idx   = AW'(pos_ff);
   assign pos1_idx  = pos_idx + AW'(1);
   assign count_idx = AW'(count_ff);
   assign last_idx  = count_idx - AW'(1);
   assign cur_idx   = AW'(cur_ff);
   assign cur1_idx  = cur_idx + AW'(1);
   assign front_m1  = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
   assign front_p1  = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);

   always_comb begin
      if (cmd.shift) begin
         rd_idx = cur_idx;
      end else begin
         case (kind_ff)
            KIND_POP_FRONT: rd_idx = '0;
            KIND_POP_BACK:  rd_idx = last_idx;
            default:        rd_idx = pos_idx;
         endcase
      end
   end

   assign rd_addr = slot_of(front_ff, rd_idx);

   always_comb begin
      if (cmd.shift) begin
         wr_addr = slot_of(front_ff, cur1_idx);
      end else begin
         case (kind_ff)
            KIND_PUSH_FRONT: wr_addr = front_m1;
            KIND_PUSH_BACK:  wr_addr = slot_of(front_ff, count_idx);
            default:         wr_addr = slot_of(front_ff, pos1_idx);
         endcase
      end
   end

   assign wr_data = cmd.shift ? rd_data_ff : val_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      kind_in = req_kind;
      if (req_kind == KIND_INSERT && count_ff == '0) begin
         kind_in = KIND_PUSH_FRONT;
      end
      front_in = front_ff;
      if (cmd.front_dec) begin
         front_in = front_m1;
      end else if (cmd.front_inc) begin
         front_in = front_p1;
      end
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      cur_in = cur_ff;
      if (cmd.cur_load) begin
         cur_in = count_ff - CW'(1);
      end else if (cmd.cur_dec) begin
         cur_in = cur_ff - CW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load_req) begin
         kind_ff <= kind_in;
         pos_ff  <= req_position;
         val_ff  <= req_item_value;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= cmd.rsp_rdata ? rd_data_ff : '0;
         rsp_count_ff  <= CNT_W'(count_in);
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign stat.kind     = kind_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.pos_bad  = (XW'(pos_ff) >= XW'(count_ff));
   assign stat.cur_more = (XW'(cur_ff) > XW'(pos_ff));
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count_now  = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
